[design/hsa_pkg.sv]
// ----------------------------------------------------------------------------
// hsa_pkg
// Shared types, codes and the handle decoder for the NaN-boxed slot allocator.
// ----------------------------------------------------------------------------
package hsa_pkg;

   localparam int DEF_SLOT_COUNT = 1024;
   localparam int PAYLOAD_BITS   = 32;
   localparam int IDX_W          = 51;
   localparam int FIRST_SLOT     = 3;

   localparam logic [63:0] EXP_MASK = 64'h7ff0_0000_0000_0000;
   localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
   localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(2);

   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_FULL       = 3'd1;
   localparam logic [2:0] ST_NOT_HANDLE = 3'd2;
   localparam logic [2:0] ST_DBL_FREE   = 3'd3;
   localparam logic [2:0] ST_INCONSIST  = 3'd4;

   localparam logic [1:0] KIND_NUMBER = 2'd0;
   localparam logic [1:0] KIND_NULL   = 2'd1;
   localparam logic [1:0] KIND_STRING = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] payload;
      logic        owned;
      logic [63:0] boxed_value;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] boxed_result;
      logic [1:0]  kind;
      logic [31:0] payload_out;
      logic        owned_out;
   } rsp_type;

   typedef struct packed {
      logic             is_handle;
      logic             neg;
      logic [IDX_W-1:0] idx;
   } handle_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_FREE,
      S_READ,
      S_DONE
   } state_type;

   function automatic handle_type decode_handle(input logic [63:0] v);
      handle_type h;
      h.idx       = v[IDX_W-1:0];
      h.neg       = v[63];
      h.is_handle = (v[62:52] == 11'h7ff) && (h.idx >= NULL_IDX) && !(&h.idx);
      return h;
   endfunction

endpackage

[design/hsa_slot_mem.sv]
// ----------------------------------------------------------------------------
// hsa_slot_mem
// Slot payload memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hsa_slot_mem #(
   parameter int SLOT_COUNT = hsa_pkg::DEF_SLOT_COUNT,
   parameter int ADDR_W     = $clog2(SLOT_COUNT)
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [ADDR_W-1:0]                wr_addr,
   input  logic [hsa_pkg::PAYLOAD_BITS-1:0] wr_data,
   input  logic [ADDR_W-1:0]                rd_addr,
   output logic [hsa_pkg::PAYLOAD_BITS-1:0] rd_data
);
   import hsa_pkg::*;

   logic [PAYLOAD_BITS-1:0] mem [SLOT_COUNT];
   logic [PAYLOAD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/hsa_ctrl.sv]
// ----------------------------------------------------------------------------
// hsa_ctrl
// Sequencer and bookkeeping: decodes a transaction, drives the slot memory
// and steps the shared increment/compare unit over slots during a reuse scan.
// ----------------------------------------------------------------------------
module hsa_ctrl #(
   parameter int SLOT_COUNT = hsa_pkg::DEF_SLOT_COUNT,
   parameter int ADDR_W     = $clog2(SLOT_COUNT),
   parameter int CNT_W      = $clog2(SLOT_COUNT + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  hsa_pkg::req_type                 req_data,
   output logic                             res_valid,
   input  logic                             res_take,
   output hsa_pkg::rsp_type                 res_data,
   output logic                             mem_we,
   output logic [ADDR_W-1:0]                mem_wr_addr,
   output logic [hsa_pkg::PAYLOAD_BITS-1:0] mem_wr_data,
   output logic [ADDR_W-1:0]                mem_rd_addr,
   input  logic [hsa_pkg::PAYLOAD_BITS-1:0] mem_rd_data
);
   import hsa_pkg::*;

   localparam logic [CNT_W-1:0] FIRST_CNT = CNT_W'(FIRST_SLOT);
   localparam logic [CNT_W-1:0] LIMIT_CNT = CNT_W'(SLOT_COUNT);

   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   rsp_type           res_ff, res_in;
   logic [CNT_W-1:0]  hw_ff, hw_in;
   logic [CNT_W-1:0]  fc_ff, fc_in;
   logic [CNT_W-1:0]  hint_ff, hint_in;
   logic [ADDR_W-1:0] scan_ff, scan_in;
   logic [ADDR_W-1:0] start_ff, start_in;

   handle_type        dec;
   logic              in_table;
   logic              fc_nz;
   logic              hw_low;
   logic              hw_full;
   logic              rd_zero;
   logic [CNT_W-1:0]  alloc_h;
   logic [CNT_W-1:0]  scan_inc;
   logic [CNT_W-1:0]  scan_nxt;
   logic              scan_wrap;
   logic [ADDR_W-1:0] dec_addr;

   assign dec      = decode_handle(req_ff.boxed_value);
   assign dec_addr = dec.idx[ADDR_W-1:0];
   assign in_table = dec.is_handle && (dec.idx >= IDX_W'(FIRST_SLOT)) &&
                     (dec.idx < IDX_W'(hw_ff));
   assign fc_nz    = (fc_ff != '0);
   assign hw_low   = (hw_ff <= FIRST_CNT);
   assign hw_full  = (hw_ff >= LIMIT_CNT);
   assign rd_zero  = (mem_rd_data == '0);
   assign alloc_h  = ((hint_ff < FIRST_CNT) || (hint_ff >= hw_ff)) ? FIRST_CNT : hint_ff;
   assign scan_inc = CNT_W'(scan_ff) + CNT_W'(1);
   assign scan_nxt = (scan_inc >= hw_ff) ? FIRST_CNT : scan_inc;
   assign scan_wrap = (scan_nxt[ADDR_W-1:0] == start_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            case (req_ff.op)
               OP_ALLOC: state_in = (fc_nz && !hw_low) ? S_SCAN : S_DONE;
               OP_FREE:  state_in = in_table ? S_FREE : S_DONE;
               OP_READ:  state_in = in_table ? S_READ : S_DONE;
               default:  state_in = S_DONE;
            endcase
         end
         S_SCAN: begin
            if (rd_zero || scan_wrap) begin
               state_in = S_DONE;
            end
         end
         S_FREE:  state_in = S_DONE;
         S_READ:  state_in = S_DONE;
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      req_in      = req_ff;
      res_in      = res_ff;
      hw_in       = hw_ff;
      fc_in       = fc_ff;
      hint_in     = hint_ff;
      scan_in     = scan_ff;
      start_in    = start_ff;
      mem_we      = 1'b0;
      mem_wr_addr = dec_addr;
      mem_wr_data = PAYLOAD_BITS'(req_ff.payload);
      mem_rd_addr = dec_addr;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               res_in = '0;
            end
         end
         S_EXEC: begin
            case (req_ff.op)
               OP_ALLOC: begin
                  if (fc_nz) begin
                     if (hw_low) begin
                        res_in.status = ST_INCONSIST;
                        fc_in         = '0;
                     end else begin
                        scan_in     = alloc_h[ADDR_W-1:0];
                        start_in    = alloc_h[ADDR_W-1:0];
                        mem_rd_addr = alloc_h[ADDR_W-1:0];
                     end
                  end else if (hw_full) begin
                     res_in.status = ST_FULL;
                  end else begin
                     mem_we              = 1'b1;
                     mem_wr_addr         = hw_ff[ADDR_W-1:0];
                     hint_in             = hw_ff;
                     hw_in               = hw_ff + CNT_W'(1);
                     res_in.boxed_result = EXP_MASK | 64'(hw_ff) |
                                           (req_ff.owned ? SIGN_BIT : 64'd0);
                     res_in.owned_out    = req_ff.owned;
                  end
               end
               OP_FREE: begin
                  if (!in_table) begin
                     res_in.status = ST_NOT_HANDLE;
                  end
               end
               OP_READ: begin
                  if (!dec.is_handle) begin
                     res_in.kind = KIND_NUMBER;
                  end else if ((dec.idx == NULL_IDX) && !dec.neg) begin
                     res_in.kind = KIND_NULL;
                  end else begin
                     res_in.kind      = KIND_STRING;
                     res_in.owned_out = dec.neg;
                     if (dec.idx >= IDX_W'(SLOT_COUNT)) begin
                        res_in.status = ST_NOT_HANDLE;
                     end
                  end
               end
               default: ;
            endcase
         end
         S_SCAN: begin
            if (rd_zero) begin
               mem_we              = 1'b1;
               mem_wr_addr         = scan_ff;
               hint_in             = CNT_W'(scan_ff);
               fc_in               = fc_ff - CNT_W'(1);
               res_in.boxed_result = EXP_MASK | 64'(scan_ff) |
                                     (req_ff.owned ? SIGN_BIT : 64'd0);
               res_in.owned_out    = req_ff.owned;
            end else if (scan_wrap) begin
               res_in.status = ST_INCONSIST;
               fc_in         = '0;
               hint_in       = CNT_W'(start_ff);
            end else begin
               scan_in     = scan_nxt[ADDR_W-1:0];
               mem_rd_addr = scan_nxt[ADDR_W-1:0];
            end
         end
         S_FREE: begin
            if (rd_zero) begin
               res_in.status = ST_DBL_FREE;
            end else begin
               mem_we           = 1'b1;
               mem_wr_data      = '0;
               fc_in            = fc_ff + CNT_W'(1);
               hint_in          = CNT_W'(dec_addr);
               res_in.owned_out = dec.neg;
            end
         end
         S_READ: begin
            res_in.payload_out = 32'(mem_rd_data);
         end
         S_DONE: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         hw_ff    <= FIRST_CNT;
         fc_ff    <= '0;
         hint_ff  <= CNT_W'(4);
      end else begin
         state_ff <= state_in;
         hw_ff    <= hw_in;
         fc_ff    <= fc_in;
         hint_ff  <= hint_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      res_ff   <= res_in;
      scan_ff  <= scan_in;
      start_ff <= start_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res_data  = res_ff;

   a_fc_bound: assert property (@(posedge clock) disable iff (reset)
      (hw_ff >= FIRST_CNT) && (hw_ff <= LIMIT_CNT) && (fc_ff <= hw_ff - FIRST_CNT))
      else $error("free count or high water out of range");

   a_wr_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (CNT_W'(mem_wr_addr) >= FIRST_CNT) && (CNT_W'(mem_wr_addr) <= hw_ff))
      else $error("slot write outside allocated range");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready && !res_valid)
      else $error("accepted transaction not executed");

   a_hand_off: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res_take) |=> !res_valid && req_ready)
      else $error("result handed off twice");

endmodule

[design/nan_boxed_handle_slot_allocator_top.sv]
// ----------------------------------------------------------------------------
// nan_boxed_handle_slot_allocator_top
// Slot allocator that hands out NaN-boxed 64-bit handles for payload words.
// ----------------------------------------------------------------------------
// One transaction at a time. Free and read of a valid table slot wait on the
// registered slot memory read. An allocate that reuses a freed slot scans the
// slot memory one slot per cycle from the hint, visiting at most high water
// minus 3 slots. A new request is accepted while the previous result still
// sits in the output register. Slots never written need no clearing pass: the
// read data is only used below the high water mark.
module nan_boxed_handle_slot_allocator_top #(
   parameter int SLOT_COUNT = hsa_pkg::DEF_SLOT_COUNT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  hsa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output hsa_pkg::rsp_type rsp_data
);
   import hsa_pkg::*;

   localparam int ADDR_W = $clog2(SLOT_COUNT);
   localparam int CNT_W  = $clog2(SLOT_COUNT + 1);

   logic                    res_valid;
   logic                    res_take;
   rsp_type                 res_data;
   logic                    mem_we;
   logic [ADDR_W-1:0]       mem_wr_addr;
   logic [PAYLOAD_BITS-1:0] mem_wr_data;
   logic [ADDR_W-1:0]       mem_rd_addr;
   logic [PAYLOAD_BITS-1:0] mem_rd_data;

   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   hsa_ctrl #(
      .SLOT_COUNT (SLOT_COUNT),
      .ADDR_W     (ADDR_W),
      .CNT_W      (CNT_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .res_valid   (res_valid),
      .res_take    (res_take),
      .res_data    (res_data),
      .mem_we      (mem_we),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   hsa_slot_mem #(
      .SLOT_COUNT (SLOT_COUNT),
      .ADDR_W     (ADDR_W)
   ) u_slot_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign res_take = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_take) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_data_in = res_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Checks the NaN-boxed slot allocator against a cycle-free behavioral model of
// its slot table. Directed transactions cover handle decoding corners, double
// frees, reserved and out-of-range indices and slot reuse; random mixes follow,
// then a fill of the table to its limit and a phase of long reuse scans. Both
// handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
   import hsa_pkg::*;

   localparam int          SLOTS     = DEF_SLOT_COUNT;
   localparam logic [1:0]  OP_UNUSED = 2'd3;
   localparam logic [50:0] IDX_TOP   = 51'h7_ffff_ffff_fffe;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   nan_boxed_handle_slot_allocator_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // model of the slot table
   logic [31:0] slot_words [SLOTS];
   int unsigned hw_mark;
   int unsigned free_slots;
   int unsigned scan_hint;
   int          full_hits;

   req_type     pending_reqs [$];
   rsp_type     expected_rsps [$];
   logic [63:0] live_boxes [$];
   int          mismatches;
   int          send_gap;
   int          recv_stall;
   bit          send_burst;
   bit          recv_burst;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] slot_box(logic [50:0] idx, bit neg);
      return {neg, 11'h7ff, 1'b0, idx};
   endfunction

   function automatic rsp_type predict_slot_op(req_type r);
      rsp_type     res;
      logic [50:0] idx;
      logic        is_hdl;
      logic        neg;
      int unsigned h;
      int unsigned start;
      int unsigned slot;
      bit          got;
      res    = '0;
      got    = 1'b0;
      slot   = 0;
      idx    = r.boxed_value[50:0];
      neg    = r.boxed_value[63];
      is_hdl = (r.boxed_value[62:52] == 11'h7ff) && (idx >= NULL_IDX) && (idx <= IDX_TOP);
      case (r.op)
         OP_ALLOC: begin
            if (free_slots != 0) begin
               if (hw_mark <= FIRST_SLOT) begin
                  res.status = ST_INCONSIST;
               end else begin
                  h = scan_hint;
                  if (h < FIRST_SLOT || h >= hw_mark) h = FIRST_SLOT;
                  start = h;
                  while (slot_words[h] != 0 && res.status == ST_OK) begin
                     h++;
                     if (h >= hw_mark) h = FIRST_SLOT;
                     if (h == start) res.status = ST_INCONSIST;
                  end
                  scan_hint = h;
                  if (res.status == ST_OK) begin
                     free_slots--;
                     slot = h;
                     got  = 1'b1;
                  end
               end
               if (res.status == ST_INCONSIST) free_slots = 0;
            end else if (hw_mark >= SLOTS) begin
               res.status = ST_FULL;
               full_hits++;
            end else begin
               slot      = hw_mark;
               scan_hint = slot;
               hw_mark++;
               got       = 1'b1;
            end
            if (got) begin
               slot_words[slot]  = r.payload;
               res.boxed_result  = EXP_MASK | 64'(slot) | (r.owned ? SIGN_BIT : 64'd0);
               res.owned_out     = r.owned;
            end
         end
         OP_FREE: begin
            if (!is_hdl || idx < FIRST_SLOT || idx >= hw_mark) begin
               res.status = ST_NOT_HANDLE;
            end else if (slot_words[idx[9:0]] == 0) begin
               res.status = ST_DBL_FREE;
            end else begin
               slot_words[idx[9:0]] = '0;
               free_slots++;
               scan_hint     = 32'(idx[9:0]);
               res.owned_out = neg;
            end
         end
         OP_READ: begin
            if (!is_hdl) begin
               res.kind = KIND_NUMBER;
            end else if (idx == NULL_IDX && !neg) begin
               res.kind = KIND_NULL;
            end else begin
               res.kind      = KIND_STRING;
               res.owned_out = neg;
               if (idx >= SLOTS) res.status = ST_NOT_HANDLE;
               else res.payload_out = slot_words[idx[9:0]];
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // driver
   always @(posedge clock) begin : drive_req
      rsp_type predicted;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && req_ready) begin
            predicted = predict_slot_op(req_data);
            expected_rsps.push_back(predicted);
         end
         if (!req_valid || req_ready) begin
            if (send_gap != 0) begin
               req_valid <= 1'b0;
               send_gap  <= send_gap - 1;
            end else if (pending_reqs.size() != 0) begin
               req_data  <= pending_reqs.pop_front();
               req_valid <= 1'b1;
               if ($urandom_range(0, 39) == 0) send_burst <= !send_burst;
               send_gap  <= send_burst ? 0 : $urandom_range(0, 12);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin : watch_rsp
      rsp_type want;
      int      n;
      if (reset) begin
         rsp_ready  <= 1'b0;
         recv_stall <= 0;
      end else if (rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transaction: status %0d boxed %h", rsp_data.status,
                        rsp_data.boxed_result);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.status !== want.status || rsp_data.boxed_result !== want.boxed_result ||
                rsp_data.kind !== want.kind || rsp_data.payload_out !== want.payload_out ||
                rsp_data.owned_out !== want.owned_out) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch exp: status %0d boxed %h kind %0d payload %h owned %0d",
                           want.status, want.boxed_result, want.kind, want.payload_out,
                           want.owned_out);
                  $display("         got: status %0d boxed %h kind %0d payload %h owned %0d",
                           rsp_data.status, rsp_data.boxed_result, rsp_data.kind,
                           rsp_data.payload_out, rsp_data.owned_out);
               end
            end
            if (want.status == ST_OK && want.boxed_result != 0)
               live_boxes.push_back(want.boxed_result);
         end
         if ($urandom_range(0, 39) == 0) recv_burst <= !recv_burst;
         n = recv_burst ? 0 : $urandom_range(0, 12);
         recv_stall <= n;
         rsp_ready  <= (n == 0);
      end else if (recv_stall != 0) begin
         recv_stall <= recv_stall - 1;
         rsp_ready  <= (recv_stall == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic queue_item(logic [1:0] op, logic [31:0] payload, logic owned,
                             logic [63:0] boxed);
      req_type r;
      r.op          = op;
      r.payload     = payload;
      r.owned       = owned;
      r.boxed_value = boxed;
      while (pending_reqs.size() >= 2) @(posedge clock);
      pending_reqs.push_back(r);
   endtask

   function automatic logic [63:0] pick_target(bit for_free);
      logic [63:0] v;
      int          k;
      int          sel;
      sel = $urandom_range(0, 99);
      if (live_boxes.size() != 0 && sel < 65) begin
         k = $urandom_range(0, live_boxes.size() - 1);
         v = live_boxes[k];
         if (for_free && $urandom_range(0, 3) != 0) live_boxes.delete(k);
         if ($urandom_range(0, 3) == 0) v[63] = ~v[63];
         v[51] = 1'($urandom_range(0, 1));
      end else if (sel < 85) begin
         v = slot_box(51'($urandom_range(0, SLOTS + 8)), 1'($urandom_range(0, 1)));
      end else begin
         v = {$urandom, $urandom};
      end
      return v;
   endfunction

   task automatic queue_random(int alloc_pct, int free_pct);
      int          pick;
      logic [31:0] payload;
      logic [63:0] boxed;
      pick    = $urandom_range(0, 99);
      payload = ($urandom_range(0, 15) == 0) ? 32'h0 : $urandom;
      boxed   = {$urandom, $urandom};
      if (pick < alloc_pct)
         queue_item(OP_ALLOC, payload, 1'($urandom_range(0, 1)), boxed);
      else if (pick < alloc_pct + free_pct)
         queue_item(OP_FREE, payload, 1'($urandom_range(0, 1)), pick_target(1'b1));
      else if (pick < 98)
         queue_item(OP_READ, payload, 1'($urandom_range(0, 1)), pick_target(1'b0));
      else
         queue_item(OP_UNUSED, payload, 1'($urandom_range(0, 1)), boxed);
   endtask

   // stimulus
   initial begin
      for (int i = 0; i < SLOTS; i++) slot_words[i] = '0;
      slot_words[1] = 32'd1;
      hw_mark    = FIRST_SLOT;
      free_slots = 0;
      scan_hint  = 4;
      full_hits  = 0;
      mismatches = 0;
      send_burst = 1'b0;
      recv_burst = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      queue_item(OP_ALLOC, 32'hffff_ffff, 1'b1, '0);
      queue_item(OP_ALLOC, 32'h0, 1'b0, '1);
      queue_item(OP_ALLOC, 32'h1234_5678, 1'b0, '0);
      queue_item(OP_FREE, '0, 1'b0, slot_box(4, 1'b0));
      queue_item(OP_FREE, '0, 1'b0, slot_box(5, 1'b1));
      queue_item(OP_FREE, '0, 1'b0, slot_box(5, 1'b0));
      queue_item(OP_FREE, '0, 1'b0, 64'h3ff0_0000_0000_0000);
      queue_item(OP_FREE, '0, 1'b0, 64'h7ff8_0000_0000_0000);
      queue_item(OP_FREE, '0, 1'b0, slot_box(1, 1'b0));
      queue_item(OP_FREE, '0, 1'b0, slot_box(2, 1'b1));
      queue_item(OP_FREE, '0, 1'b0, slot_box(100, 1'b0));
      queue_item(OP_FREE, '0, 1'b0, slot_box(IDX_TOP, 1'b0));
      queue_item(OP_READ, '0, 1'b0, slot_box(2, 1'b0));
      queue_item(OP_READ, '0, 1'b0, slot_box(2, 1'b1));
      queue_item(OP_READ, '0, 1'b0, slot_box(3, 1'b1) | 64'h0008_0000_0000_0000);
      queue_item(OP_READ, '0, 1'b0, slot_box(IDX_TOP, 1'b0));
      queue_item(OP_READ, '0, 1'b0, slot_box('1, 1'b1));
      queue_item(OP_READ, '0, 1'b0, slot_box(51'(SLOTS), 1'b0));
      queue_item(OP_READ, '0, 1'b0, slot_box(51'(SLOTS - 1), 1'b1));
      queue_item(OP_READ, '0, 1'b0, 64'h0);
      queue_item(OP_READ, '1, 1'b1, '1);
      queue_item(OP_UNUSED, '1, 1'b1, '1);
      queue_item(OP_ALLOC, 32'h0000_0001, 1'b1, '0);
      queue_item(OP_ALLOC, 32'hdead_beef, 1'b0, '0);
      queue_item(OP_READ, '0, 1'b0, slot_box(5, 1'b0));

      repeat (300) queue_random(45, 30);
      while (full_hits < 6) queue_random(92, 0);
      repeat (200) queue_random(40, 35);

      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(negedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

   initial begin
      #60000000;
      $display("testbench: errors");
      $finish;
   end

endmodule

[sim.f]
design/hsa_pkg.sv
design/hsa_slot_mem.sv
design/hsa_ctrl.sv
design/nan_boxed_handle_slot_allocator_top.sv
tb/testbench.sv
